// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by small_matrix_inverse.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication on every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== hw/rtl/smi_pkg.sv =====
package smi_pkg;

  localparam int ELEM_W = 32;
  localparam int NCOF   = 9;
  // Cofactor: difference of two 64-bit products
  localparam int COF_W  = 65;
  // Determinant term: element times cofactor
  localparam int TERM_W = ELEM_W + COF_W;
  // Sum of three terms
  localparam int DET_W  = TERM_W + 2;
  localparam int CMAG_W = COF_W;
  localparam int DMAG_W = DET_W;
  // Quotient bits kept before saturation
  localparam int QBITS  = ELEM_W + 1;

  localparam logic [QBITS:0] LIM_NEG = (QBITS+1)'(64'd1 << (ELEM_W - 1));
  localparam logic [QBITS:0] LIM_POS = LIM_NEG - (QBITS+1)'(1);

  // matrix_size codes; any value other than 2x2 selects 3x3
  localparam logic [1:0] SIZE_2X2 = 2'd2;
  localparam logic [1:0] SIZE_3X3 = 2'd3;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r01;
    logic signed [ELEM_W-1:0] r02;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic                     singular;
    logic                     saturated;
  } inv_t;

  // Magnitudes and signs handed from the front end to the divider
  typedef struct packed {
    logic [NCOF-1:0][CMAG_W-1:0] cmag;
    logic [NCOF-1:0]             neg;
    logic [DMAG_W-1:0]           dmag;
    logic                        singular;
  } div_in_t;

endpackage

// ===== hw/rtl/smi_stream_if.sv =====
interface smi_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/smi_divider.sv =====
module smi_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  smi_pkg::div_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output smi_pkg::inv_t    out_data
);
  import smi_pkg::*;

  localparam int RW    = DMAG_W + QBITS + 1;

  typedef struct packed {
    logic [NCOF-1:0][RW-1:0]    rem;
    logic [NCOF-1:0][QBITS-1:0] quo;
    logic [NCOF-1:0]            ovf;
    logic [NCOF-1:0]            neg;
    logic [DMAG_W-1:0]          dmag;
    logic                       singular;
  } div_st_t;

  div_st_t st     [QBITS+1];
  logic    st_v   [QBITS+1];
  logic    st_rdy [QBITS+2];
  div_st_t st0_next;
  inv_t    fin_next;
  logic    fin_rdy;

  assign in_ready         = st_rdy[0];
  assign fin_rdy          = !out_valid || out_ready;
  assign st_rdy[QBITS+1]  = fin_rdy;
  assign st_rdy[0]        = !st_v[0] || st_rdy[1];

  // Scale numerators and flag quotients too large for the quotient bits
  always_comb begin
    logic [RW-1:0] num;
    st0_next          = '0;
    st0_next.neg      = in_data.neg;
    st0_next.dmag     = in_data.dmag;
    st0_next.singular = in_data.singular;
    for (int i = 0; i < NCOF; i++) begin
      num = RW'({in_data.cmag[i], {(2*FRAC_BITS){1'b0}}});
      st0_next.rem[i] = num;
      st0_next.ovf[i] = num >= RW'({in_data.dmag, {QBITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (st_rdy[0]) begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_rdy[0]) begin
      st[0] <= st0_next;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= QBITS; j++) begin : g_bit
    localparam int K = QBITS - j;
    div_st_t       nx;
    logic [RW-1:0] trial;

    assign trial     = RW'(st[j-1].dmag) << K;
    assign st_rdy[j] = !st_v[j] || st_rdy[j+1];

    always_comb begin
      nx = st[j-1];
      for (int i = 0; i < NCOF; i++) begin
        if (st[j-1].rem[i] >= trial) begin
          nx.rem[i]    = st[j-1].rem[i] - trial;
          nx.quo[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j] <= 1'b0;
      end else if (st_rdy[j]) begin
        st_v[j] <= st_v[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[j]) begin
        st[j] <= nx;
      end
    end
  end

  // Round half away from zero, clamp, apply sign, zero singular words
  always_comb begin
    logic [QBITS:0]                  qr;
    logic [QBITS:0]                  lim;
    logic [RW-1:0]                   rem2;
    logic [ELEM_W-1:0]               mag;
    logic [NCOF-1:0][ELEM_W-1:0]     r;
    logic                            sat;
    sat = 1'b0;
    for (int i = 0; i < NCOF; i++) begin
      rem2 = {st[QBITS].rem[i][RW-2:0], 1'b0};
      qr   = {1'b0, st[QBITS].quo[i]} +
             (QBITS+1)'(rem2 >= RW'(st[QBITS].dmag));
      lim  = st[QBITS].neg[i] ? LIM_NEG : LIM_POS;
      if (st[QBITS].ovf[i] || (qr > lim)) begin
        mag = lim[ELEM_W-1:0];
        sat = 1'b1;
      end else begin
        mag = qr[ELEM_W-1:0];
      end
      r[i] = st[QBITS].neg[i] ? -mag : mag;
    end
    if (st[QBITS].singular) begin
      r   = '0;
      sat = 1'b0;
    end
    fin_next.r00       = r[0];
    fin_next.r01       = r[1];
    fin_next.r02       = r[2];
    fin_next.r10       = r[3];
    fin_next.r11       = r[4];
    fin_next.r12       = r[5];
    fin_next.r20       = r[6];
    fin_next.r21       = r[7];
    fin_next.r22       = r[8];
    fin_next.singular  = st[QBITS].singular;
    fin_next.saturated = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_rdy) begin
      out_valid <= st_v[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_rdy) begin
      out_data <= fin_next;
    end
  end

endmodule

// ===== hw/rtl/small_matrix_inverse.sv =====
// Channel   Role    Word
// matrix    sink    mat_t: nine signed Q elements a00..a22
// inverse   source  inv_t: nine signed Q elements r00..r22, singular, saturated
// cfg       write   cfg_wr_en / cfg_wr_data: matrix_size (2 = 2x2, else 3x3)
//
// Six front-end stages (products, cofactors, split determinant multiply,
// term merge, determinant sum, magnitudes) feed one scaling stage, 33
// restoring-division stages and one rounding stage.
// One word enters per cycle while the output is not stalled; each stage
// holds its own valid bit and takes a new word whenever it is empty or its
// successor takes its word, so a stall at the output fills bubbles and
// drops nothing. rst clears all valid bits and sets matrix_size to 3.
`include "assert_macros.svh"

module small_matrix_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  smi_stream_if.sink   matrix,
  smi_stream_if.source inverse,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);
  import smi_pkg::*;

  logic [1:0] matrix_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_3X3;
    end else if (cfg_wr_en) begin
      matrix_size <= cfg_wr_data;
    end
  end

  // Handshake chain
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, div_rdy;

  assign rdy6         = !s6_v || div_rdy;
  assign rdy5         = !s5_v || rdy6;
  assign rdy4         = !s4_v || rdy5;
  assign rdy3         = !s3_v || rdy4;
  assign rdy2         = !s2_v || rdy3;
  assign rdy1         = !s1_v || rdy2;
  assign matrix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      if (rdy1) s1_v <= matrix.valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
      if (rdy4) s4_v <= s3_v;
      if (rdy5) s5_v <= s4_v;
      if (rdy6) s6_v <= s5_v;
    end
  end

  // Stage 1: the eighteen 2x2 minor products
  logic signed [ELEM_W-1:0]   a    [9];
  logic signed [2*ELEM_W-1:0] p    [18];
  logic signed [2*ELEM_W-1:0] s1_p [18];
  logic signed [ELEM_W-1:0]   s1_a [5];
  logic                       s1_mode2;

  assign a[0] = matrix.data.a00;
  assign a[1] = matrix.data.a01;
  assign a[2] = matrix.data.a02;
  assign a[3] = matrix.data.a10;
  assign a[4] = matrix.data.a11;
  assign a[5] = matrix.data.a12;
  assign a[6] = matrix.data.a20;
  assign a[7] = matrix.data.a21;
  assign a[8] = matrix.data.a22;

  always_comb begin
    p[0]  = a[4] * a[8];
    p[1]  = a[7] * a[5];
    p[2]  = a[2] * a[7];
    p[3]  = a[1] * a[8];
    p[4]  = a[1] * a[5];
    p[5]  = a[2] * a[4];
    p[6]  = a[5] * a[6];
    p[7]  = a[3] * a[8];
    p[8]  = a[0] * a[8];
    p[9]  = a[2] * a[6];
    p[10] = a[3] * a[2];
    p[11] = a[0] * a[5];
    p[12] = a[3] * a[7];
    p[13] = a[6] * a[4];
    p[14] = a[6] * a[1];
    p[15] = a[0] * a[7];
    p[16] = a[0] * a[4];
    p[17] = a[3] * a[1];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_p     <= p;
      s1_a     <= a[0:4];
      s1_mode2 <= (matrix_size == SIZE_2X2);
    end
  end

  // Stage 2: cofactors, or the swapped and negated elements in 2x2 mode
  logic signed [COF_W-1:0]  c3     [9];
  logic signed [COF_W-1:0]  cof    [9];
  logic signed [COF_W-1:0]  s2_cof [9];
  logic signed [ELEM_W-1:0] s2_a   [3];
  logic signed [COF_W-1:0]  s2_det2;
  logic                     s2_mode2;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      c3[i] = COF_W'(s1_p[2*i]) - COF_W'(s1_p[2*i+1]);
    end
    if (s1_mode2) begin
      for (int i = 0; i < 9; i++) begin
        cof[i] = '0;
      end
      cof[0] = COF_W'(s1_a[4]);
      cof[1] = -COF_W'(s1_a[1]);
      cof[3] = -COF_W'(s1_a[3]);
      cof[4] = COF_W'(s1_a[0]);
    end else begin
      cof = c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cof   <= cof;
      s2_a     <= s1_a[0:2];
      s2_det2  <= c3[8];
      s2_mode2 <= s1_mode2;
    end
  end

  // Stage 3: first-row element times cofactor, split in low and high halves
  logic signed [COF_W-1:0] s3_pl  [3];
  logic signed [COF_W-1:0] s3_ph  [3];
  logic signed [COF_W-1:0] s3_cof [9];
  logic signed [COF_W-1:0] s3_det2;
  logic                    s3_mode2;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int k = 0; k < 3; k++) begin
        s3_pl[k] <= s2_a[k] * $signed({1'b0, s2_cof[3*k][ELEM_W-1:0]});
        s3_ph[k] <= s2_a[k] * $signed(s2_cof[3*k][COF_W-1:ELEM_W]);
      end
      s3_cof   <= s2_cof;
      s3_det2  <= s2_det2;
      s3_mode2 <= s2_mode2;
    end
  end

  // Stage 4: merge halves into full determinant terms
  logic signed [TERM_W-1:0] s4_t   [3];
  logic signed [COF_W-1:0]  s4_cof [9];
  logic signed [COF_W-1:0]  s4_det2;
  logic                     s4_mode2;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int k = 0; k < 3; k++) begin
        s4_t[k] <= $signed({s3_ph[k], {ELEM_W{1'b0}}}) + TERM_W'(s3_pl[k]);
      end
      s4_cof   <= s3_cof;
      s4_det2  <= s3_det2;
      s4_mode2 <= s3_mode2;
    end
  end

  // Stage 5: determinant
  logic signed [DET_W-1:0] s5_det;
  logic signed [COF_W-1:0] s5_cof [9];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_det <= s4_mode2 ? DET_W'(s4_det2)
                         : DET_W'(s4_t[0]) + DET_W'(s4_t[1]) + DET_W'(s4_t[2]);
      s5_cof <= s4_cof;
    end
  end

  // Stage 6: magnitudes, result signs and the singular flag
  div_in_t s6_next;
  div_in_t s6_d;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      s6_next.cmag[i] = CMAG_W'(s5_cof[i][COF_W-1] ? -s5_cof[i] : s5_cof[i]);
      s6_next.neg[i]  = s5_cof[i][COF_W-1] ^ s5_det[DET_W-1];
    end
    s6_next.dmag     = DMAG_W'(s5_det[DET_W-1] ? -s5_det : s5_det);
    s6_next.singular = (s5_det == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_d <= s6_next;
    end
  end

  // Divide, round and saturate
  smi_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_v),
    .in_ready  (div_rdy),
    .in_data   (s6_d),
    .out_valid (inverse.valid),
    .out_ready (inverse.ready),
    .out_data  (inverse.data)
  );

  `ASSERT_NEVER(a_sing_no_sat, clk, rst, inverse.valid && inverse.data.singular && inverse.data.saturated, "singular word flagged saturated")
  `ASSERT_PROP(a_sing_zero, clk, rst, (inverse.valid && inverse.data.singular) |-> (inverse.data.r00 == '0 && inverse.data.r11 == '0 && inverse.data.r22 == '0), "singular word has nonzero elements")
  `ASSERT_PROP(a_accept_lands, clk, rst, (matrix.valid && matrix.ready) |=> s1_v, "accepted word missing from first stage")
  `ASSERT_PROP(a_s6_hold, clk, rst, (s6_v && !div_rdy) |=> (s6_v && $stable(s6_d)), "stalled front-end word lost or changed")

endmodule

// ===== dv/small_matrix_inverse_checker.sv =====
module small_matrix_inverse_checker (
  input  logic        clk,
  input  logic        rst,
  smi_stream_if       matrix,
  smi_stream_if       inverse,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  import smi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;
  localparam int FRAC = 16;
  localparam int INV_W = $bits(inv_t);

  localparam string FIELD_NAME [11] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                         "r20", "r21", "r22", "singular", "saturated"};

  inv_t inverse_q [$];
  logic [1:0] size_reg;

  // Rounded, saturated num * 2^(2*FRAC) / den
  function automatic logic [31:0] scaled_quotient(wide_t num, wide_t den, inout bit sat);
    logic [255:0] n, d, q, r, lim;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    n = n << (2 * FRAC);
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    neg = ((num < 0) != (den < 0)) && (q != 0);
    lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? (32'd0 - q[31:0]) : q[31:0];
  endfunction

  // Adjugate inverse of one matrix word
  function automatic inv_t adjugate_inverse(mat_t m, bit two_by_two);
    wide_t a [9];
    wide_t c [9];
    wide_t det;
    logic [31:0] r [9];
    bit sat;
    inv_t res;
    a[0] = wide_t'(m.a00); a[1] = wide_t'(m.a01); a[2] = wide_t'(m.a02);
    a[3] = wide_t'(m.a10); a[4] = wide_t'(m.a11); a[5] = wide_t'(m.a12);
    a[6] = wide_t'(m.a20); a[7] = wide_t'(m.a21); a[8] = wide_t'(m.a22);
    sat = 1'b0;
    if (two_by_two) begin
      foreach (c[i]) c[i] = '0;
      c[0] = a[4];
      c[1] = -a[1];
      c[3] = -a[3];
      c[4] = a[0];
      det = a[0] * a[4] - a[1] * a[3];
    end else begin
      c[0] = a[4] * a[8] - a[7] * a[5];
      c[1] = a[2] * a[7] - a[1] * a[8];
      c[2] = a[1] * a[5] - a[2] * a[4];
      c[3] = a[5] * a[6] - a[3] * a[8];
      c[4] = a[0] * a[8] - a[2] * a[6];
      c[5] = a[3] * a[2] - a[0] * a[5];
      c[6] = a[3] * a[7] - a[6] * a[4];
      c[7] = a[6] * a[1] - a[0] * a[7];
      c[8] = a[0] * a[4] - a[3] * a[1];
      det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
    end
    res = '0;
    if (det == 0) begin
      res.singular = 1'b1;
      return res;
    end
    foreach (r[i]) r[i] = scaled_quotient(c[i], det, sat);
    res.r00 = r[0]; res.r01 = r[1]; res.r02 = r[2];
    res.r10 = r[3]; res.r11 = r[4]; res.r12 = r[5];
    res.r20 = r[6]; res.r21 = r[7]; res.r22 = r[8];
    res.saturated = sat;
    return res;
  endfunction

  assign pending = inverse_q.size();

  // Predict on each matrix word, compare each inverse word, track the size register
  always @(posedge clk) begin
    inv_t want, got;
    logic [31:0] w, g;
    bit bad;
    if (rst) begin
      size_reg <= SIZE_3X3;
    end else begin
      if (matrix.valid && matrix.ready)
        inverse_q.push_back(adjugate_inverse(matrix.data, size_reg == SIZE_2X2));
      if (inverse.valid && inverse.ready) begin
        got = inverse.data;
        if (inverse_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected inverse word %h", got);
        end else begin
          want = inverse_q.pop_front();
          bad = 1'b0;
          for (int k = 0; k < 11; k++) begin
            if (k < 9) begin
              w = want[INV_W-1-32*k -: 32];
              g = got[INV_W-1-32*k -: 32];
            end else begin
              w = {31'd0, want[10-k]};
              g = {31'd0, got[10-k]};
            end
            if (w !== g) begin
              if (!bad) fail_count = fail_count + 1;
              if (!bad && fail_count <= 10)
                $display("mismatch %s: expected %h, got %h", FIELD_NAME[k], w, g);
              bad = 1'b1;
            end
          end
        end
      end
      if (cfg_wr_en) size_reg <= cfg_wr_data;
    end
  end

  initial fail_count = 0;
endmodule

// ===== dv/small_matrix_inverse_tb.sv =====
module small_matrix_inverse_tb;
  import smi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 41;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [1:0] SIZE_ALT0 = 2'd0;
  localparam logic [1:0] SIZE_ALT1 = 2'd1;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [1:0] cfg_wr_data;
  int fail_count;
  int pending;
  bit long_hold_req;
  bit calm;
  int idle_cycles;

  smi_stream_if #(.T(mat_t)) matrix_ch ();
  smi_stream_if #(.T(inv_t)) inverse_ch ();

  small_matrix_inverse DUT (
    .clk(clk), .rst(rst), .matrix(matrix_ch), .inverse(inverse_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  small_matrix_inverse_checker checker_inst (
    .clk(clk), .rst(rst), .matrix(matrix_ch), .inverse(inverse_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (matrix_ch.valid && matrix_ch.ready) || (inverse_ch.valid && inverse_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drain side: random gaps per word, one long hold-off on request
  initial begin
    int gap;
    inverse_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (long_hold_req) begin
        gap = 400;
        long_hold_req = 1'b0;
      end
      repeat (gap) begin
        inverse_ch.ready <= 1'b0;
        @(negedge clk);
      end
      inverse_ch.ready <= 1'b1;
      do @(posedge clk); while (!(inverse_ch.valid && inverse_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_matrix(mat_t m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      matrix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    matrix_ch.valid <= 1'b1;
    matrix_ch.data <= m;
    do @(posedge clk); while (!(matrix_ch.valid && matrix_ch.ready));
    @(negedge clk);
  endtask

  // Drain the pipeline, then write the size register
  task automatic set_size(logic [1:0] v);
    matrix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_elem(int kind);
    logic [31:0] corner [8];
    corner = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               Q_ONE, -Q_ONE, 32'h0000_8000};
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      2: return corner[$urandom_range(0, 7)];
      default: return $urandom_range(0, 32'h100) - 32'h80;
    endcase
  endfunction

  function automatic mat_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    mat_t m;
    m = '0;
    m.a00 = d0;
    m.a11 = d1;
    m.a22 = d2;
    return m;
  endfunction

  // Mostly well-conditioned matrices, plus full-range, corner, singular and tiny ones
  function automatic mat_t random_matrix();
    mat_t m;
    int pick, kind;
    pick = $urandom_range(0, 99);
    kind = (pick < 55) ? 1 : (pick < 72) ? 0 : (pick < 84) ? 2 : 3;
    m.a00 = pick_elem(kind); m.a01 = pick_elem(kind); m.a02 = pick_elem(kind);
    m.a10 = pick_elem(kind); m.a11 = pick_elem(kind); m.a12 = pick_elem(kind);
    m.a20 = pick_elem(kind); m.a21 = pick_elem(kind); m.a22 = pick_elem(kind);
    if (pick >= 92) begin
      // copy a row so the determinant is zero in both modes
      m.a10 = m.a00;
      m.a11 = m.a01;
      m.a12 = m.a02;
    end
    return m;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2) && (i < n / 2 + 20);
      send_matrix(random_matrix());
    end
    calm = 1'b0;
  endtask

  initial begin
    mat_t m;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = SIZE_3X3;
    matrix_ch.valid = 1'b0;
    matrix_ch.data = '0;
    long_hold_req = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_size(SIZE_3X3);
    // Identity, scaled, zero, tiny (saturating), corners
    send_matrix(diag(Q_ONE, Q_ONE, Q_ONE));
    send_matrix(diag(Q_ONE << 1, -Q_ONE, 32'h0000_4000));
    send_matrix('0);
    send_matrix(diag(32'h1, 32'h1, 32'h1));
    send_matrix(diag(32'h1, 32'hFFFF_FFFF, 32'h1));
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix('1);
    send_matrix({9{32'h8000_0000}});
    // Rounding: quotients with a remainder of one third
    send_matrix(diag(32'h0003_0000, 32'h0000_0003, 32'hFFFD_0000));
    m = random_matrix();
    send_matrix(m);
    long_hold_req = 1'b1;
    random_phase(PHASE_ITEMS);

    set_size(SIZE_2X2);
    send_matrix(diag(Q_ONE, Q_ONE, 32'h0));
    send_matrix({Q_ONE, Q_ONE, 32'h1234_5678, Q_ONE, Q_ONE, {4{32'h7FFF_FFFF}}});
    send_matrix(diag(32'h1, 32'h8000_0000, 32'h0));
    send_matrix(diag(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_matrix({32'h0, Q_ONE, 32'h0, -Q_ONE, 32'h0, {4{32'h0}}});
    random_phase(PHASE_ITEMS);

    set_size(SIZE_ALT0);
    send_matrix(diag(Q_ONE, Q_ONE, Q_ONE));
    random_phase(PHASE_ITEMS);
    set_size(SIZE_ALT1);
    send_matrix(diag(32'h1, Q_ONE, Q_ONE));
    random_phase(PHASE_ITEMS);
    set_size(SIZE_2X2);
    random_phase(PHASE_ITEMS);
    set_size(SIZE_3X3);
    random_phase(PHASE_ITEMS);

    // Drain, then give the pipeline time to show any stray word
    matrix_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY * 2) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/smi_pkg.sv
hw/rtl/smi_stream_if.sv
hw/rtl/smi_divider.sv
hw/rtl/small_matrix_inverse.sv
dv/small_matrix_inverse_checker.sv
dv/small_matrix_inverse_tb.sv
